>>> design/sliding_window_median_top_macros.svh
// Assertion macros for the sliding window median top level.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define SWM_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> design/swm_pkg.sv
// Shared constants and types for the sliding window median block.
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int AGE_BITS_DEF    = $clog2(WINDOW_MAX_DEF);

    localparam int PORT_BITS    = 32;
    localparam int LEN_BITS     = 5;
    localparam int COUNT_BITS   = 5;
    localparam int KIND_BITS    = 2;

    localparam logic [LEN_BITS-1:0] WINDOW_LEN_RESET = 5'd16;

    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DROP   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

    // Broadcast control for every cell of the sorted chain.
    typedef struct packed {
        logic step;   // apply an update this cycle
        logic ins;    // insert the new sample
        logic rm_en;  // remove the oldest sample
        logic clr;    // empty the chain
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/sliding_window_median_top.sv
// Top level of the sliding window median block: control, cell chain and result register.
//
// Usage:
// The input channel (in_valid, in_ready, kind, sample) carries one transaction per
// item: insert a sample, drop the oldest sample, or clear the window. Every
// accepted transaction produces exactly one result transaction on the output
// channel (out_valid, out_ready, median, median_valid, sample_count).
// The window length register is written through cfg_wr_en and cfg_wr_data and
// should only be changed while the block is idle, preferably after a clear.
// The cell chain and the fill count update when an item is accepted; the block
// then enters ST_MEDIAN, where the median is selected from the chain and
// registered in the output register. No new item is accepted in ST_MEDIAN, so
// the block does not take a new item before the last one's result is registered.
// Reset clears the chain's valid bits, the fill count and the output register,
// and sets the window length to sixteen.
// When the receiver stalls, the result stays in the output register and no new
// transaction is accepted until it has been taken; a transaction may be
// accepted in the same cycle the waiting result is taken.
`default_nettype none

module sliding_window_median_top #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [swm_pkg::KIND_BITS-1:0]      kind,
    input  logic signed [swm_pkg::PORT_BITS-1:0] sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [swm_pkg::PORT_BITS-1:0] median,
    output logic                               median_valid,
    output logic [swm_pkg::COUNT_BITS-1:0]     sample_count,
    input  logic                               cfg_wr_en,
    input  logic [swm_pkg::LEN_BITS-1:0]       cfg_wr_data
);
    import swm_pkg::*;

    `include "sliding_window_median_top_macros.svh"

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_W = (CNT_W > LEN_BITS) ? CNT_W : LEN_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_MEDIAN
    } state_t;

    state_t state_reg, state_next;

    logic                   out_valid_reg, out_valid_next;
    logic [PORT_BITS-1:0]   median_reg, median_next;
    logic                   median_valid_reg, median_valid_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    logic [LEN_BITS-1:0]    window_len_reg;
    logic [CNT_W-1:0]       fill_reg, fill_next;

    logic                   accept;
    logic                   is_ins;
    logic                   is_drop;
    logic                   is_clr;
    logic [CMP_W-1:0]       eff_len;
    logic                   full;
    cell_ctrl_t             ctrl;
    logic [SAMPLE_BITS-1:0] new_value;
    logic [AGE_W-1:0]       oldest_age;
    logic [SAMPLE_BITS-1:0] chain_median;

    logic [WINDOW_MAX-1:0]  cell_valid;
    logic [AGE_W-1:0]       cell_age [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  sh_valid;
    logic [AGE_W-1:0]       sh_age [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] sh_value [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  gone;
    logic [WINDOW_MAX-1:0]  lt;

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_len_reg <= cfg_wr_data;
        end
    end

    // A length of zero behaves as one, and lengths beyond the chain are capped.
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            eff_len = CMP_W'(1);
        end
        else if (CMP_W'(window_len_reg) > CMP_W'(WINDOW_MAX))
        begin
            eff_len = CMP_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = CMP_W'(window_len_reg);
        end
    end

    // ------------------------------------------------------------------
    // Item decode and fill count.
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign is_ins  = (kind == KIND_INSERT);
    assign is_drop = (kind == KIND_DROP);
    assign is_clr  = (kind == KIND_CLEAR);
    assign full    = (CMP_W'(fill_reg) >= eff_len);

    // An insert into a full window removes the oldest sample in the same cycle.
    assign ctrl.step  = accept && (is_ins || is_drop || is_clr);
    assign ctrl.ins   = is_ins;
    assign ctrl.clr   = is_clr;
    assign ctrl.rm_en = (is_ins && full) || is_drop;

    assign oldest_age = AGE_W'(fill_reg - 1'b1);

    generate
        if (SAMPLE_BITS > PORT_BITS)
        begin : g_in_wide
            assign new_value = {{(SAMPLE_BITS - PORT_BITS){1'b0}}, sample};
        end
        else
        begin : g_in_narrow
            assign new_value = sample[SAMPLE_BITS-1:0];
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            if (is_ins)
            begin
                if (!full)
                begin
                    fill_next = CNT_W'(fill_reg + 1'b1);
                end
            end
            else if (is_drop)
            begin
                if (fill_reg != '0)
                begin
                    fill_next = CNT_W'(fill_reg - 1'b1);
                end
            end
            else if (is_clr)
            begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // ------------------------------------------------------------------
    // Sorted chain. Cell zero holds the smallest sample. Removal closes the
    // gap by pulling from the upper neighbor, and insertion opens one by
    // pulling from the lower neighbor, both within the same update.
    // ------------------------------------------------------------------
    generate
        for (genvar g = 0; g < WINDOW_MAX; g++)
        begin : g_cell
            logic                   up_valid_w;
            logic [AGE_W-1:0]       up_age_w;
            logic [SAMPLE_BITS-1:0] up_value_w;
            logic                   gone_in_w;
            logic                   below_lt_w;
            logic                   dn_valid_w;
            logic [AGE_W-1:0]       dn_age_w;
            logic [SAMPLE_BITS-1:0] dn_value_w;

            if (g == WINDOW_MAX - 1)
            begin : g_top_end
                assign up_valid_w = 1'b0;
                assign up_age_w   = '0;
                assign up_value_w = '0;
            end
            else
            begin : g_top_link
                assign up_valid_w = cell_valid[g+1];
                assign up_age_w   = cell_age[g+1];
                assign up_value_w = cell_value[g+1];
            end

            if (g == 0)
            begin : g_bot_end
                assign gone_in_w  = 1'b0;
                assign below_lt_w = 1'b1;
                assign dn_valid_w = 1'b0;
                assign dn_age_w   = '0;
                assign dn_value_w = '0;
            end
            else
            begin : g_bot_link
                assign gone_in_w  = gone[g-1];
                assign below_lt_w = lt[g-1];
                assign dn_valid_w = sh_valid[g-1];
                assign dn_age_w   = sh_age[g-1];
                assign dn_value_w = sh_value[g-1];
            end

            swm_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_W       (AGE_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (new_value),
                .oldest_age (oldest_age),
                .up_valid   (up_valid_w),
                .up_age     (up_age_w),
                .up_value   (up_value_w),
                .gone_in    (gone_in_w),
                .below_lt   (below_lt_w),
                .dn_valid   (dn_valid_w),
                .dn_age     (dn_age_w),
                .dn_value   (dn_value_w),
                .gone_out   (gone[g]),
                .lt_out     (lt[g]),
                .sh_valid   (sh_valid[g]),
                .sh_age     (sh_age[g]),
                .sh_value   (sh_value[g]),
                .cur_valid  (cell_valid[g]),
                .cur_age    (cell_age[g]),
                .cur_value  (cell_value[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Median selection from the settled chain.
    // ------------------------------------------------------------------
    swm_median #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_median (
        .values (cell_value),
        .fill   (fill_reg),
        .median (chain_median)
    );

    // ------------------------------------------------------------------
    // Sequencer and result register.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        median_next       = median_reg;
        median_valid_next = median_valid_reg;
        count_next        = count_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MEDIAN;
                end
            end
            ST_MEDIAN:
            begin
                // The chain and the fill count were updated at the previous edge.
                if (SAMPLE_BITS >= PORT_BITS)
                begin
                    median_next = chain_median[PORT_BITS-1:0];
                end
                else
                begin
                    median_next = PORT_BITS'($signed(chain_median));
                end
                median_valid_next = (fill_reg != '0);
                count_next        = COUNT_BITS'(fill_reg);
                out_valid_next    = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            median_reg       <= '0;
            median_valid_reg <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            median_reg       <= median_next;
            median_valid_reg <= median_valid_next;
            count_reg        <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median       = median_reg;
    assign median_valid = median_valid_reg;
    assign sample_count = count_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `SWM_ASSERT_ALWAYS(a_fill_cells, $countones(cell_valid) == int'(fill_reg), "bad fill count")
    `SWM_ASSERT_ALWAYS(a_cells_packed, ((cell_valid + 1'b1) & cell_valid) == '0, "gap in cells")
    `SWM_ASSERT_ALWAYS(a_fill_bound, CNT_W'(WINDOW_MAX) >= fill_reg, "fill beyond chain")
    `SWM_ASSERT_NEXT(a_result, state_reg == ST_MEDIAN, out_valid_reg, "result missing")

endmodule

`default_nettype wire

>>> design/swm_cell.sv
// One cell of the sorted sample chain: holds a value, its age and a valid bit.
`default_nettype none

module swm_cell #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int AGE_W       = swm_pkg::AGE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swm_pkg::cell_ctrl_t    ctrl,
    input  logic [SAMPLE_BITS-1:0] new_value,
    input  logic [AGE_W-1:0]       oldest_age,
    input  logic                   up_valid,
    input  logic [AGE_W-1:0]       up_age,
    input  logic [SAMPLE_BITS-1:0] up_value,
    input  logic                   gone_in,
    input  logic                   below_lt,
    input  logic                   dn_valid,
    input  logic [AGE_W-1:0]       dn_age,
    input  logic [SAMPLE_BITS-1:0] dn_value,
    output logic                   gone_out,
    output logic                   lt_out,
    output logic                   sh_valid,
    output logic [AGE_W-1:0]       sh_age,
    output logic [SAMPLE_BITS-1:0] sh_value,
    output logic                   cur_valid,
    output logic [AGE_W-1:0]       cur_age,
    output logic [SAMPLE_BITS-1:0] cur_value
);
    import swm_pkg::*;

    logic                   valid_reg, valid_next;
    logic [AGE_W-1:0]       age_reg, age_next;
    logic [SAMPLE_BITS-1:0] value_reg, value_next;
    logic                   rm_here;

    // The oldest sample is the one whose age equals the count minus one.
    assign rm_here  = ctrl.rm_en && valid_reg && (age_reg == oldest_age);
    assign gone_out = gone_in || rm_here;

    // Contents of this position once the removed entry has closed its gap.
    assign sh_valid = gone_out ? up_valid : valid_reg;
    assign sh_age   = gone_out ? up_age   : age_reg;
    assign sh_value = gone_out ? up_value : value_reg;

    // Strict compare places a new sample before existing equal ones.
    assign lt_out = sh_valid && ($signed(sh_value) < $signed(new_value));

    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        value_next = value_reg;
        if (ctrl.step)
        begin
            if (ctrl.clr)
            begin
                valid_next = 1'b0;
            end
            else if (ctrl.ins)
            begin
                if (lt_out)
                begin
                    valid_next = sh_valid;
                    age_next   = AGE_W'(sh_age + 1'b1);
                    value_next = sh_value;
                end
                else if (below_lt)
                begin
                    valid_next = 1'b1;
                    age_next   = '0;
                    value_next = new_value;
                end
                else
                begin
                    valid_next = dn_valid;
                    age_next   = AGE_W'(dn_age + 1'b1);
                    value_next = dn_value;
                end
            end
            else
            begin
                valid_next = sh_valid;
                age_next   = sh_age;
                value_next = sh_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg   <= age_next;
        value_reg <= value_next;
    end

    assign cur_valid = valid_reg;
    assign cur_age   = age_reg;
    assign cur_value = value_reg;

endmodule

`default_nettype wire

>>> design/swm_median.sv
// Picks the middle entries of the sorted chain and forms the median.
`default_nettype none

module swm_median #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(swm_pkg::WINDOW_MAX_DEF + 1)
) (
    input  logic [SAMPLE_BITS-1:0] values [WINDOW_MAX],
    input  logic [CNT_W-1:0]       fill,
    output logic [SAMPLE_BITS-1:0] median
);
    import swm_pkg::*;

    logic [CNT_W-1:0]       hi_idx;
    logic [CNT_W-1:0]       lo_idx;
    logic [SAMPLE_BITS-1:0] hi_val;
    logic [SAMPLE_BITS-1:0] lo_val;
    logic [SAMPLE_BITS-1:0] half_diff;
    logic [SAMPLE_BITS-1:0] mean_val;

    assign hi_idx = fill >> 1;
    assign lo_idx = CNT_W'(hi_idx - 1'b1);

    // Each cell is compared against the two middle positions; at most one matches each.
    always_comb
    begin
        hi_val = '0;
        lo_val = '0;
        for (int j = 0; j < WINDOW_MAX; j++)
        begin
            if (CNT_W'(j) == hi_idx)
            begin
                hi_val = hi_val | values[j];
            end
            if (CNT_W'(j) == lo_idx)
            begin
                lo_val = lo_val | values[j];
            end
        end
    end

    // Floored mean without overflow: common bits plus half of the differing bits.
    assign half_diff = SAMPLE_BITS'($signed(hi_val ^ lo_val) >>> 1);
    assign mean_val  = SAMPLE_BITS'((hi_val & lo_val) + half_diff);

    always_comb
    begin
        if (fill == '0)
        begin
            median = '0;
        end
        else if (fill[0])
        begin
            median = hi_val;
        end
        else
        begin
            median = mean_val;
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the sliding window median block.
`timescale 1ns / 1ps

// Stimulus:
// A short directed run covers the special cases: drop and unused kind on an
// empty window, the sample extremes, equal samples, a clear followed by a
// drop, and a drop that empties the window. Ten random phases follow; each
// writes the window length register before its items, after a clear in odd
// phases. The values include zero, one, sixteen and the largest 5-bit value.
// The window is not cleared before every write, so a length lowered below
// the current count is exercised too.
//
// Checking:
// The window_tracker class keeps its own arrival ring and sorted copy of the
// window. For every accepted input transaction it queues the expected count
// and median. Each result transaction is compared with the oldest entry in
// that queue.
module tb_top;

    import swm_pkg::*;

    localparam int WIN = 16;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam int CLK_HALF = 4;
    localparam int HOLD_CYCLES = 250;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 170;
    localparam int DIRECTED_ITEMS = 22;

    // Predicts the count and median after every transaction and holds the
    // predictions until the matching result transaction arrives.
    class window_tracker;
        typedef struct {
            logic signed [31:0] median;
            logic               valid;
            logic [4:0]         count;
        } median_rec_t;

        logic signed [31:0] ring [WIN];
        logic signed [31:0] ordered [WIN];
        int fill;
        int head;
        int tail;
        int win_len;
        median_rec_t pending_medians[$];
        int mismatches;

        function new();
            fill = 0;
            head = 0;
            tail = 0;
            win_len = int'(WINDOW_LEN_RESET);
            mismatches = 0;
        endfunction

        function void set_len(logic [LEN_BITS-1:0] len);
            win_len = int'(len);
        endfunction

        // A length of zero behaves as one, anything above the store depth as
        // the full depth.
        function int held_limit();
            if (win_len == 0)
                return 1;
            if (win_len > WIN)
                return WIN;
            return win_len;
        endfunction

        function void drop_oldest();
            logic signed [31:0] v;
            int pos;
            if (fill == 0)
                return;
            v = ring[head];
            head = (head + 1) % WIN;
            pos = fill - 1;
            for (int i = fill - 1; i >= 0; i--)
                if (ordered[i] == v)
                    pos = i;
            for (int i = pos; i + 1 < fill; i++)
                ordered[i] = ordered[i + 1];
            fill--;
            if (fill == 0)
            begin
                head = 0;
                tail = 0;
            end
        endfunction

        function void add_sample(logic signed [31:0] v);
            int pos;
            if (fill >= held_limit())
                drop_oldest();
            pos = 0;
            while (pos < fill && ordered[pos] < v)
                pos++;
            for (int i = fill; i > pos; i--)
                ordered[i] = ordered[i - 1];
            ordered[pos] = v;
            ring[tail] = v;
            tail = (tail + 1) % WIN;
            fill++;
        endfunction

        function median_rec_t window_median();
            median_rec_t r;
            logic signed [32:0] pair_sum;
            r.count = 5'(fill);
            r.valid = (fill != 0);
            r.median = '0;
            if (fill % 2 == 1)
                r.median = ordered[fill / 2];
            else if (fill != 0)
            begin
                pair_sum = ordered[fill / 2 - 1] + ordered[fill / 2];
                r.median = pair_sum[32:1];
            end
            return r;
        endfunction

        function void take_item(logic [KIND_BITS-1:0] k, logic signed [31:0] s);
            case (k)
                KIND_INSERT: add_sample(s);
                KIND_DROP:   drop_oldest();
                KIND_CLEAR:
                begin
                    fill = 0;
                    head = 0;
                    tail = 0;
                end
                default: ;
            endcase
            pending_medians.push_back(window_median());
        endfunction

        function void check_result(logic signed [31:0] m, logic v, logic [4:0] c);
            median_rec_t exp_rec;
            if (pending_medians.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: median %0d valid %b count %0d",
                             $realtime, m, v, c);
                return;
            end
            exp_rec = pending_medians.pop_front();
            if (m !== exp_rec.median || v !== exp_rec.valid || c !== exp_rec.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected median %0d valid %b count %0d, got %0d %b %0d",
                             $realtime, exp_rec.median, exp_rec.valid, exp_rec.count, m, v, c);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [KIND_BITS-1:0] kind = KIND_INSERT;
    logic signed [PORT_BITS-1:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [PORT_BITS-1:0] median;
    logic median_valid;
    logic [COUNT_BITS-1:0] sample_count;
    logic cfg_wr_en = 1'b0;
    logic [LEN_BITS-1:0] cfg_wr_data = '0;

    // Idling switches, set per phase by the stimulus process.
    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;
    // Asks the receiver for one long hold-off.
    bit hold_req = 1'b0;
    int cycles = 0;

    window_tracker tracker = new();

    // Directed items: the sample extremes, equal samples, the unused kind and
    // drops on an empty window, both before any insert and right after a clear.
    logic [KIND_BITS-1:0] dir_kind [DIRECTED_ITEMS] = '{
        KIND_DROP, KIND_UNUSED, KIND_INSERT, KIND_INSERT, KIND_INSERT,
        KIND_INSERT, KIND_INSERT, KIND_INSERT, KIND_INSERT, KIND_UNUSED,
        KIND_DROP, KIND_DROP, KIND_INSERT, KIND_INSERT, KIND_CLEAR,
        KIND_DROP, KIND_INSERT, KIND_INSERT, KIND_DROP, KIND_DROP,
        KIND_INSERT, KIND_INSERT
    };
    logic [31:0] dir_sample [DIRECTED_ITEMS] = '{
        32'h1234_5678, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
        32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0001_0000, 32'hFFFF_FFFF,
        32'h0000_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000,
        32'h7FFF_FFFF, 32'h7FFF_FFFE
    };

    // Window lengths for the random phases; zero and values above the store
    // depth are legal register contents and must be clamped by the block.
    logic [LEN_BITS-1:0] phase_len [PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd12, 5'd3, 5'd16
    };

    sliding_window_median_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median       (median),
        .median_valid (median_valid),
        .sample_count (sample_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Offers one input transaction, with an optional random gap before it, and
    // returns at the edge where it is accepted. Valid stays high on return so
    // that back-to-back transactions need no extra assignment.
    task automatic offer_item(logic [KIND_BITS-1:0] k, logic [31:0] s);
        int gap;
        gap = 0;
        if (sender_idle && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        sample <= s;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_item(k, s);
    endtask

    // The register is only written with no transaction in flight: valid is
    // dropped, every pending result is collected, and the output stage is
    // left to settle before the write.
    task automatic write_window_len(logic [LEN_BITS-1:0] len);
        in_valid <= 1'b0;
        while (tracker.pending_medians.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_len(len);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            // A narrow range makes equal samples common.
            2, 3, 4: return 32'(int'($urandom_range(0, 16)) - 8);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [KIND_BITS-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 74)
            return KIND_INSERT;
        if (r < 90)
            return KIND_DROP;
        if (r < 94)
            return KIND_CLEAR;
        return KIND_UNUSED;
    endfunction

    // Receiver: checks every result transaction and stalls in random bursts,
    // plus one long hold-off that lets the block fill up and stall its input.
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_result(median, median_valid, sample_count);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (receiver_idle && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Main stimulus.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs with the reset window length of sixteen.
        for (int i = 0; i < DIRECTED_ITEMS; i++)
            offer_item(dir_kind[i], dir_sample[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            // Odd phases start from an empty window, the others keep the
            // current contents across the length change.
            if (p % 2 == 1)
                offer_item(KIND_CLEAR, $urandom());
            write_window_len(phase_len[p]);
            // Some phases run with no idling at all, and so does the last one.
            sender_idle = (p % 3 != 1) && (p != PHASES - 1);
            receiver_idle = sender_idle;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 0 && i == 20)
                begin
                    hold_req = 1'b1;
                    sender_idle = 1'b0;
                end
                if (p == 0 && i == 60)
                    sender_idle = 1'b1;
                offer_item(pick_kind(), pick_sample());
            end
        end

        in_valid <= 1'b0;
        while (tracker.pending_medians.size() != 0)
            @(posedge clk);
        // Catch any stray result the block might still produce.
        repeat (8) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending_medians.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
